>>> rtl/srpq_pkg.sv
// shared types and constants for the sorted priority queue
package srpq_pkg;

   localparam int SLOTS = 256;
   localparam int CELLS = SLOTS - 1;
   localparam int CNT_W = $clog2(SLOTS);
   localparam int KEY_W = 32;
   localparam int PAY_W = 9;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [PAY_W-1:0] pay_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef struct packed {
      logic ins;
      logic rem;
   } cell_ctrl_type;

endpackage

>>> rtl/srpq_cell.sv
// one storage cell of the sorted chain, shifting to either neighbour
module srpq_cell
   import srpq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  key_type       new_key,
   input  pay_type       new_payload,
   input  logic          occ,
   input  logic          prev_take,
   input  key_type       prev_key,
   input  pay_type       prev_payload,
   input  key_type       next_key,
   input  pay_type       next_payload,
   output logic          take,
   output key_type       key,
   output pay_type       payload
);

   key_type key_ff;
   key_type key_in;
   pay_type payload_ff;
   pay_type payload_in;

   // slot where the new entry or a shifted one lands
   assign take    = !occ || (key_ff >= new_key);
   assign key     = key_ff;
   assign payload = payload_ff;

   always_comb begin
      priority if (ctrl.rem) begin
         key_in     = next_key;
         payload_in = next_payload;
      end else if (ctrl.ins && prev_take) begin
         key_in     = prev_key;
         payload_in = prev_payload;
      end else if (ctrl.ins && take) begin
         key_in     = new_key;
         payload_in = new_payload;
      end else begin
         key_in     = key_ff;
         payload_in = payload_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

endmodule

>>> rtl/sorted_ring_priority_queue_unit.sv
// sorted priority queue built as a chain of shifting cells
// response: registered, valid in the cycle after the request is accepted
// throughput: one request per cycle while the response is not stalled; every cell compares in parallel
// reset: synchronous, empties the queue and drops any pending response
// cell contents are not reset; only occupied cells are ever read
module sorted_ring_priority_queue_unit
   import srpq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  logic    req_cmd,
   input  key_type req_key,
   input  pay_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output logic    rsp_ok,
   output key_type rsp_out_key,
   output pay_type rsp_out_payload,
   output logic    rsp_now_empty,
   output logic    rsp_now_full
);

   cnt_type       count_ff;
   cnt_type       count_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          rsp_ok_ff;
   logic          rsp_ok_in;
   key_type       rsp_key_ff;
   key_type       rsp_key_in;
   pay_type       rsp_payload_ff;
   pay_type       rsp_payload_in;
   logic          rsp_empty_ff;
   logic          rsp_empty_in;
   logic          rsp_full_ff;
   logic          rsp_full_in;

   logic          accept;
   logic          is_empty;
   logic          is_full;
   cell_ctrl_type ctrl;
   logic [CELLS-1:0] occ;
   logic [CELLS-1:0] take;
   key_type       cell_key [CELLS];
   pay_type       cell_pay [CELLS];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == cnt_type'(CELLS));

   assign ctrl.ins = accept && (req_cmd == CMD_INSERT) && !is_full;
   assign ctrl.rem = accept && (req_cmd == CMD_REMOVE) && !is_empty;

   always_comb begin
      for (int i = 0; i < CELLS; i++) begin
         occ[i] = (count_ff > cnt_type'(i));
      end
   end

   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      logic    prev_take;
      key_type prev_key;
      pay_type prev_pay;
      key_type next_key;
      pay_type next_pay;

      if (g == 0) begin : g_first
         assign prev_take = 1'b0;
         assign prev_key  = '0;
         assign prev_pay  = '0;
      end else begin : g_inner
         assign prev_take = take[g-1];
         assign prev_key  = cell_key[g-1];
         assign prev_pay  = cell_pay[g-1];
      end

      if (g == CELLS - 1) begin : g_last
         assign next_key = '0;
         assign next_pay = '0;
      end else begin : g_body
         assign next_key = cell_key[g+1];
         assign next_pay = cell_pay[g+1];
      end

      srpq_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .new_key      (req_key),
         .new_payload  (req_payload),
         .occ          (occ[g]),
         .prev_take    (prev_take),
         .prev_key     (prev_key),
         .prev_payload (prev_pay),
         .next_key     (next_key),
         .next_payload (next_pay),
         .take         (take[g]),
         .key          (cell_key[g]),
         .payload      (cell_pay[g])
      );
   end

   always_comb begin
      priority if (ctrl.ins) begin
         count_in = count_ff + cnt_type'(1);
      end else if (ctrl.rem) begin
         count_in = count_ff - cnt_type'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_ok_in      = rsp_ok_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_full_in    = rsp_full_ff;
      if (accept) begin
         rsp_valid_in   = 1'b1;
         rsp_ok_in      = ctrl.ins || ctrl.rem;
         rsp_key_in     = ctrl.rem ? cell_key[0] : '0;
         rsp_payload_in = ctrl.rem ? cell_pay[0] : '0;
         rsp_empty_in   = (count_in == '0);
         rsp_full_in    = (count_in == cnt_type'(CELLS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff      <= rsp_ok_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_full_ff    <= rsp_full_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_payload = rsp_payload_ff;
   assign rsp_now_empty   = rsp_empty_ff;
   assign rsp_now_full    = rsp_full_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(CELLS))
      else $error("occupancy beyond capacity");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request gave no response");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_key_ff == '0 && rsp_payload_ff == '0))
      else $error("refused request returned data");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.rem |=> (count_ff == $past(count_ff) - cnt_type'(1)) && rsp_ok_ff)
      else $error("remove did not shrink the queue");
`endif

endmodule
